>>> rtl/core/w3sf_pkg.sv
// ----------------------------------------------------------------------------
// w3sf_pkg
// Shared constants, types and a function of the weighted 3x3 smoothing filter.
// ----------------------------------------------------------------------------
`default_nettype none
package w3sf_pkg;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned PixW      = 8;

  localparam logic [1:0] RegFrameWidth   = 2'd0;
  localparam logic [1:0] RegFrameHeight  = 2'd1;
  localparam logic [1:0] RegCenterWeight = 2'd2;
  localparam logic [1:0] RegDivisor      = 2'd3;

  typedef logic [PixW-1:0] pix_t;

  // The divisor's reciprocal scaled by 2^17 and rounded up. Multiplying a value
  // below 4096 by it and dropping 17 bits gives the exact truncated quotient.
  // A zero divisor acts as one.
  function automatic logic [17:0] recip(input logic [4:0] d);
    logic [17:0] r;
    case (d)
      5'd2:    r = 18'd65536;
      5'd3:    r = 18'd43691;
      5'd4:    r = 18'd32768;
      5'd5:    r = 18'd26215;
      5'd6:    r = 18'd21846;
      5'd7:    r = 18'd18725;
      5'd8:    r = 18'd16384;
      5'd9:    r = 18'd14564;
      5'd10:   r = 18'd13108;
      5'd11:   r = 18'd11916;
      5'd12:   r = 18'd10923;
      5'd13:   r = 18'd10083;
      5'd14:   r = 18'd9363;
      5'd15:   r = 18'd8739;
      5'd16:   r = 18'd8192;
      5'd17:   r = 18'd7711;
      5'd18:   r = 18'd7282;
      5'd19:   r = 18'd6899;
      5'd20:   r = 18'd6554;
      5'd21:   r = 18'd6242;
      5'd22:   r = 18'd5958;
      5'd23:   r = 18'd5699;
      5'd24:   r = 18'd5462;
      5'd25:   r = 18'd5243;
      5'd26:   r = 18'd5042;
      5'd27:   r = 18'd4855;
      5'd28:   r = 18'd4682;
      5'd29:   r = 18'd4520;
      5'd30:   r = 18'd4370;
      5'd31:   r = 18'd4229;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/weighted_3x3_smoothing_filter.sv
// ----------------------------------------------------------------------------
// weighted_3x3_smoothing_filter
// Center-weighted 3x3 mean filter over a raster stream of red samples.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_axis  | in        | tdata[7:0] pixel_red, tuser drain
//  m_axis  | out       | tdata[7:0] filtered, tlast last_of_frame
//  cfg     | in        | cfg_index_i register index, cfg_data_i value
// An item with a result passes through accept, line store read and
// write-back, the addition of the window terms one at a time, and the
// output register load. An item without a result ends after the write-back;
// a drain item at the frame start is only accepted.
// The input is not ready while an item is in work; the last step waits while
// the output register holds an item that is not taken.
// Reset clears counters, window and registers, but presets the config; line stores are not cleared.
`default_nettype none
module weighted_3x3_smoothing_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // pixel_red
  input  wire logic        s_axis_tuser,  // drain
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,  // filtered
  output logic             m_axis_tlast,  // last_of_frame
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StCalc = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  logic [10:0] width_q, height_q;
  logic [3:0]  cweight_q;
  logic [4:0]  div_q;

  state_e      state_q;
  logic [10:0] col_q, row_q;
  logic [19:0] emit_q;
  logic [10:0] ucol_q;
  logic        have_q;
  logic [10:0] tr_q, tc_q;
  w3sf_pkg::pix_t px_q;
  w3sf_pkg::pix_t win_q [3][3];
  logic [11:0] cen_q;
  logic [17:0] recip_q;
  logic [1:0]  dr_q, dc_q;
  logic [12:0] acc_q;
  logic        out_v_q, out_last_q;
  logic [7:0]  out_q;

  logic [10:0] w_c, h_c;
  logic [21:0] total_c;
  logic        restart_c, accept_c, skip_c, have_c;
  logic [10:0] c0_c, r0_c, cnext_c, rnext_c, tr_c, tc_c;
  logic [19:0] e0_c;
  logic [20:0] emit_inc_c;
  logic        last_c, out_free_c;
  logic [7:0]  sat_c;
  w3sf_pkg::pix_t rd_a, rd_b;
  logic        ram_we_c;
  logic [w3sf_pkg::AddrW-1:0] ram_addr_c;
  logic [11:0] term_v_c;
  logic [29:0] prod_c;
  logic        row_ok_c, col_ok_c;

  assign cfg_ready_o   = (state_q == StIdle);
  assign s_axis_tready = (state_q == StIdle);
  assign accept_c      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd640;
      height_q  <= 11'd480;
      cweight_q <= 4'd5;
      div_q     <= 5'd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        w3sf_pkg::RegFrameWidth:   width_q   <= cfg_data_i;
        w3sf_pkg::RegFrameHeight:  height_q  <= cfg_data_i;
        w3sf_pkg::RegCenterWeight: cweight_q <= cfg_data_i[3:0];
        w3sf_pkg::RegDivisor:      div_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = (width_q < 11'd2) ? 11'd2 :
          (width_q > 11'(w3sf_pkg::MaxWidth)) ? 11'(w3sf_pkg::MaxWidth) : width_q;
    h_c = (height_q < 11'd2) ? 11'd2 :
          (height_q > 11'(w3sf_pkg::MaxHeight)) ? 11'(w3sf_pkg::MaxHeight) : height_q;
    total_c = {11'd0, w_c} * {11'd0, h_c};
  end

  // Frame position of the item being accepted, after any restart.
  always_comb begin
    restart_c = (col_q >= w_c) || (12'(row_q) > 12'(h_c) + 12'd1) ||
                ({2'b00, emit_q} >= total_c);
    c0_c = restart_c ? '0 : col_q;
    r0_c = restart_c ? '0 : row_q;
    e0_c = restart_c ? '0 : emit_q;
    skip_c = s_axis_tuser && (c0_c == '0) && (r0_c == '0);
    cnext_c = c0_c + 11'd1;
    rnext_c = r0_c;
    if (cnext_c >= w_c) begin
      cnext_c = '0;
      rnext_c = r0_c + 11'd1;
    end
    have_c = 1'b0;
    tr_c = '0;
    tc_c = '0;
    if (c0_c == '0 && r0_c >= 11'd2) begin
      have_c = 1'b1;
      tr_c = r0_c - 11'd2;
      tc_c = w_c - 11'd1;
    end else if (c0_c != '0 && r0_c != '0) begin
      have_c = 1'b1;
      tr_c = r0_c - 11'd1;
      tc_c = c0_c - 11'd1;
    end
  end

  assign ram_we_c   = (state_q == StRead);
  assign ram_addr_c = ram_we_c ? ucol_q[w3sf_pkg::AddrW-1:0] : c0_c[w3sf_pkg::AddrW-1:0];

  w3sf_ram #(.Width(w3sf_pkg::PixW), .Depth(w3sf_pkg::MaxWidth)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (ram_we_c),
    .addr_i  (ram_addr_c),
    .wdata_i (px_q),
    .rdata_o (rd_a)
  );
  w3sf_ram #(.Width(w3sf_pkg::PixW), .Depth(w3sf_pkg::MaxWidth)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (ram_we_c),
    .addr_i  (ram_addr_c),
    .wdata_i (rd_a),
    .rdata_o (rd_b)
  );

  // One window term per cycle: bounds check and reciprocal division.
  always_comb begin
    term_v_c = (dr_q == 2'd1 && dc_q == 2'd1) ? cen_q : {4'd0, win_q[dr_q][dc_q]};
    prod_c = {18'd0, term_v_c} * {12'd0, recip_q};
    case (dr_q)
      2'd0:    row_ok_c = (tr_q != '0);
      2'd1:    row_ok_c = (tr_q < h_c);
      default: row_ok_c = (12'(tr_q) + 12'd1 < 12'(h_c));
    endcase
    case (dc_q)
      2'd0:    col_ok_c = (tc_q != '0);
      2'd1:    col_ok_c = (tc_q < w_c);
      default: col_ok_c = (12'(tc_q) + 12'd1 < 12'(w_c));
    endcase
  end

  always_comb begin
    emit_inc_c = {1'b0, emit_q} + 21'd1;
    last_c = ({1'b0, emit_inc_c} >= total_c);
    sat_c = (acc_q > 13'd255) ? 8'd255 : acc_q[7:0];
    out_free_c = !out_v_q || m_axis_tready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      col_q      <= '0;
      row_q      <= '0;
      emit_q     <= '0;
      ucol_q     <= '0;
      have_q     <= 1'b0;
      tr_q       <= '0;
      tc_q       <= '0;
      px_q       <= '0;
      cen_q      <= '0;
      recip_q    <= '0;
      dr_q       <= '0;
      dc_q       <= '0;
      acc_q      <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_q      <= '0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          win_q[a][b] <= '0;
        end
      end
    end else begin
      case (state_q)
        StIdle: begin
          if (accept_c) begin
            emit_q <= e0_c;
            if (skip_c) begin
              col_q <= c0_c;
              row_q <= r0_c;
            end else begin
              col_q   <= cnext_c;
              row_q   <= rnext_c;
              ucol_q  <= c0_c;
              have_q  <= have_c;
              tr_q    <= tr_c;
              tc_q    <= tc_c;
              px_q    <= s_axis_tuser ? 8'd0 : s_axis_tdata;
              state_q <= StRead;
            end
          end
        end
        StRead: begin
          for (int k = 0; k < 3; k++) begin
            win_q[k][0] <= win_q[k][1];
            win_q[k][1] <= win_q[k][2];
          end
          win_q[0][2] <= rd_b;
          win_q[1][2] <= rd_a;
          win_q[2][2] <= px_q;
          cen_q   <= 12'(cweight_q) * 12'(win_q[1][2]);
          recip_q <= w3sf_pkg::recip(div_q);
          dr_q    <= '0;
          dc_q    <= '0;
          acc_q   <= '0;
          state_q <= have_q ? StCalc : StIdle;
        end
        StCalc: begin
          if (row_ok_c && col_ok_c) begin
            acc_q <= acc_q + {1'b0, prod_c[28:17]};
          end
          if (dc_q == 2'd2) begin
            dc_q <= '0;
            if (dr_q == 2'd2) begin
              state_q <= StOut;
            end else begin
              dr_q <= dr_q + 2'd1;
            end
          end else begin
            dc_q <= dc_q + 2'd1;
          end
        end
        StOut: begin
          if (out_free_c) begin
            out_q      <= sat_c;
            out_last_q <= last_c;
            if (last_c) begin
              emit_q <= '0;
              col_q  <= '0;
              row_q  <= '0;
            end else begin
              emit_q <= emit_inc_c[19:0];
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (state_q == StOut && out_free_c) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> (out_v_q && $stable(out_q) && $stable(out_last_q)))
    else $error("result changed while waiting");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < 11'(w3sf_pkg::MaxWidth)) else $error("column out of range");
`endif
endmodule
`default_nettype wire

>>> rtl/core/w3sf_ram.sv
// ----------------------------------------------------------------------------
// w3sf_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module w3sf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire
